>>> hdl/cpa_pkg.sv
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared types and constants of the color page pool allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package cpa_pkg;

  // Color geometry: the color of a frame is its low COLOR_W bits.
  localparam int COLORS    = 64;
  localparam int COLOR_W   = 6;
  localparam int MAX_RUN   = 64;

  // Field widths
  localparam int FRAME_BITS = 20;
  localparam int CMD_W      = 2;
  localparam int CTX_REQ_W  = 6;
  localparam int STATUS_W   = 2;
  localparam int QUOTA_W    = 11;
  localparam int RUN_W      = 7;

  // Default sizes of the storage
  localparam int FRAMES_PER_COLOR = 1024;
  localparam int CONTEXTS         = 64;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [QUOTA_W-1:0] QUOTA_RESET = 11'd1024;
  localparam logic [RUN_W-1:0]   RUN_RESET   = 7'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_DEPOSIT = 2'd0,
    CMD_OPEN    = 2'd1,
    CMD_ALLOC   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_OOM       = 2'd2,
    ST_NO_COLORS = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_QUOTA     = 1'd0,
    CFG_COLORS_PER_CTX = 1'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEP_CHK,
    S_ALC_LD,
    S_ALC_CHK,
    S_ALC_POP,
    S_RESP
  } state_e;

  // One context slot: first color, run length and allocation cursor
  typedef struct packed {
    logic [COLOR_W-1:0] first;
    logic [RUN_W-1:0]   count;
    logic [COLOR_W-1:0] cursor;
  } ctx_ent_t;

endpackage

`default_nettype wire

>>> hdl/cpa_req_if.sv
// ----------------------------------------------------------------------------
// cpa_req_if
// Command channel of the allocator: deposit, open context, allocate.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpa_req_if;
  logic                            valid;
  logic                            ready;
  logic [cpa_pkg::CMD_W-1:0]       cmd;
  logic [cpa_pkg::FRAME_BITS-1:0]  frame;
  logic [cpa_pkg::CTX_REQ_W-1:0]   context_req;

  modport source (output valid, output cmd, output frame, output context_req, input ready);
  modport sink   (input valid, input cmd, input frame, input context_req, output ready);
endinterface

`default_nettype wire

>>> hdl/cpa_rsp_if.sv
// ----------------------------------------------------------------------------
// cpa_rsp_if
// Result channel of the allocator: one item per command.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpa_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [cpa_pkg::STATUS_W-1:0]    status;
  logic [cpa_pkg::FRAME_BITS-1:0]  out_frame;
  logic [cpa_pkg::COLOR_W-1:0]     out_color;

  modport source (output valid, output status, output out_frame, output out_color, input ready);
  modport sink   (input valid, input status, input out_frame, input out_color, output ready);
endinterface

`default_nettype wire

>>> hdl/cpa_cfg_if.sv
// ----------------------------------------------------------------------------
// cpa_cfg_if
// Register write channel of the allocator.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpa_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [cpa_pkg::CFG_IDX_W-1:0]    idx;
  logic [cpa_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/color_page_pool_allocator.sv
// ----------------------------------------------------------------------------
// color_page_pool_allocator
// Cache-colored page frame pool with per-context color runs.
// ----------------------------------------------------------------------------
// One command is in work at a time; the result sits in an output register,
// so the next command is taken while the previous result waits. A deposit
// checks the fill count of its color, then pushes the frame; an open-context,
// an unused command 3 or a slot out of range goes straight to the result.
// An allocate loads its context slot, then tries the colors of its run in
// turn from the cursor until one holds a frame, which it pops (every color
// is tried when all are empty; a context with no colors tries none). Every
// try is one read of the per-color fill-count memory, which has one read
// port, so a run of up to 64 colors sets the worst case. The next command
// is taken in the cycle after a result is loaded; a result still waiting
// when the next one is ready holds the sequencer until it is taken. Reset
// is immediate; fill counts and context slots start empty through valid
// bits, with no clearing pass. Frames pop in LIFO order per color.
`default_nettype none

module color_page_pool_allocator #(
  parameter int FRAMES_PER_COLOR = cpa_pkg::FRAMES_PER_COLOR,
  parameter int CONTEXTS         = cpa_pkg::CONTEXTS
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cpa_req_if.sink   req_i,
  cpa_rsp_if.source rsp_o,
  cpa_cfg_if.sink   cfg_i
);

  localparam int CNT_W     = $clog2(FRAMES_PER_COLOR + 1);
  localparam int IDX_W     = (FRAMES_PER_COLOR > 1) ? $clog2(FRAMES_PER_COLOR) : 1;
  localparam int FRM_AW    = cpa_pkg::COLOR_W + IDX_W;
  // context_req reaches no slot above 63
  localparam int CTX_DEPTH = (CONTEXTS < (1 << cpa_pkg::CTX_REQ_W)) ?
                             CONTEXTS : (1 << cpa_pkg::CTX_REQ_W);
  localparam int CTX_AW    = (CTX_DEPTH > 1) ? $clog2(CTX_DEPTH) : 1;

  logic [cpa_pkg::COLOR_W-1:0]    cnt_rd_addr, cnt_wr_addr;
  logic [CNT_W-1:0]               cnt_rd_data, cnt_wr_data;
  logic                           cnt_wr_en;
  logic [CTX_AW-1:0]              ctx_rd_addr, ctx_wr_addr;
  cpa_pkg::ctx_ent_t              ctx_rd_data, ctx_wr_data;
  logic                           ctx_wr_en;
  logic [FRM_AW-1:0]              frm_rd_addr, frm_wr_addr;
  logic [cpa_pkg::FRAME_BITS-1:0] frm_rd_data, frm_wr_data;
  logic                           frm_wr_en;

  cpa_seq #(
    .FRAMES_PER_COLOR (FRAMES_PER_COLOR),
    .CONTEXTS         (CONTEXTS),
    .CNT_W            (CNT_W),
    .IDX_W            (IDX_W),
    .CTX_AW           (CTX_AW)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req           (req_i),
    .rsp           (rsp_o),
    .cfg           (cfg_i),
    .cnt_rd_addr_o (cnt_rd_addr),
    .cnt_rd_data_i (cnt_rd_data),
    .cnt_wr_en_o   (cnt_wr_en),
    .cnt_wr_addr_o (cnt_wr_addr),
    .cnt_wr_data_o (cnt_wr_data),
    .ctx_rd_addr_o (ctx_rd_addr),
    .ctx_rd_data_i (ctx_rd_data),
    .ctx_wr_en_o   (ctx_wr_en),
    .ctx_wr_addr_o (ctx_wr_addr),
    .ctx_wr_data_o (ctx_wr_data),
    .frm_rd_addr_o (frm_rd_addr),
    .frm_rd_data_i (frm_rd_data),
    .frm_wr_en_o   (frm_wr_en),
    .frm_wr_addr_o (frm_wr_addr),
    .frm_wr_data_o (frm_wr_data)
  );

  cpa_count_mem #(
    .CNT_W (CNT_W)
  ) u_count_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (cnt_rd_addr),
    .rd_data_o (cnt_rd_data),
    .wr_en_i   (cnt_wr_en),
    .wr_addr_i (cnt_wr_addr),
    .wr_data_i (cnt_wr_data)
  );

  cpa_ctx_mem #(
    .DEPTH (CTX_DEPTH),
    .AW    (CTX_AW)
  ) u_ctx_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (ctx_rd_addr),
    .rd_data_o (ctx_rd_data),
    .wr_en_i   (ctx_wr_en),
    .wr_addr_i (ctx_wr_addr),
    .wr_data_i (ctx_wr_data)
  );

  cpa_frame_mem #(
    .AW (FRM_AW)
  ) u_frame_mem (
    .clk_i     (clk_i),
    .rd_addr_i (frm_rd_addr),
    .rd_data_o (frm_rd_data),
    .wr_en_i   (frm_wr_en),
    .wr_addr_i (frm_wr_addr),
    .wr_data_i (frm_wr_data)
  );

endmodule

`default_nettype wire

>>> hdl/cpa_count_mem.sv
// ----------------------------------------------------------------------------
// cpa_count_mem
// Per-color fill counts: one write and one registered read per cycle.
// A color never written reads as zero through its valid bit.
// ----------------------------------------------------------------------------
`default_nettype none

module cpa_count_mem #(
  parameter int CNT_W = 11
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [cpa_pkg::COLOR_W-1:0] rd_addr_i,
  output logic      [CNT_W-1:0]            rd_data_o,
  input  wire logic                        wr_en_i,
  input  wire logic [cpa_pkg::COLOR_W-1:0] wr_addr_i,
  input  wire logic [CNT_W-1:0]            wr_data_i
);

  logic [CNT_W-1:0]            mem [cpa_pkg::COLORS];
  logic [CNT_W-1:0]            rd_data_q;
  logic [cpa_pkg::COLORS-1:0]  vld_q;
  logic                        rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

>>> hdl/cpa_ctx_mem.sv
// ----------------------------------------------------------------------------
// cpa_ctx_mem
// Context slot table: first color, run length and cursor of each slot.
// A slot never written reads as all zero (no colors).
// ----------------------------------------------------------------------------
`default_nettype none

module cpa_ctx_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [AW-1:0]     rd_addr_i,
  output cpa_pkg::ctx_ent_t      rd_data_o,
  input  wire logic              wr_en_i,
  input  wire logic [AW-1:0]     wr_addr_i,
  input  cpa_pkg::ctx_ent_t      wr_data_i
);

  cpa_pkg::ctx_ent_t mem [DEPTH];
  cpa_pkg::ctx_ent_t rd_data_q;
  logic [DEPTH-1:0]  vld_q;
  logic              rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

>>> hdl/cpa_frame_mem.sv
// ----------------------------------------------------------------------------
// cpa_frame_mem
// Frame stacks of all colors, addressed as {color, stack slot}.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module cpa_frame_mem #(
  parameter int AW = 16
) (
  input  wire logic                           clk_i,
  input  wire logic [AW-1:0]                  rd_addr_i,
  output logic      [cpa_pkg::FRAME_BITS-1:0] rd_data_o,
  input  wire logic                           wr_en_i,
  input  wire logic [AW-1:0]                  wr_addr_i,
  input  wire logic [cpa_pkg::FRAME_BITS-1:0] wr_data_i
);

  localparam int DEPTH = 1 << AW;

  logic [cpa_pkg::FRAME_BITS-1:0] mem [DEPTH];
  logic [cpa_pkg::FRAME_BITS-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> hdl/cpa_seq.sv
// ----------------------------------------------------------------------------
// cpa_seq
// Command sequencer: walks one command through the count, context and
// frame memories, one color try per cycle, and holds the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module cpa_seq #(
  parameter int FRAMES_PER_COLOR = cpa_pkg::FRAMES_PER_COLOR,
  parameter int CONTEXTS         = cpa_pkg::CONTEXTS,
  parameter int CNT_W            = 11,
  parameter int IDX_W            = 10,
  parameter int CTX_AW           = 6
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  cpa_req_if.sink                                req,
  cpa_rsp_if.source                              rsp,
  cpa_cfg_if.sink                                cfg,
  // fill counts
  output logic      [cpa_pkg::COLOR_W-1:0]       cnt_rd_addr_o,
  input  wire logic [CNT_W-1:0]                  cnt_rd_data_i,
  output logic                                   cnt_wr_en_o,
  output logic      [cpa_pkg::COLOR_W-1:0]       cnt_wr_addr_o,
  output logic      [CNT_W-1:0]                  cnt_wr_data_o,
  // context slots
  output logic      [CTX_AW-1:0]                 ctx_rd_addr_o,
  input  cpa_pkg::ctx_ent_t                      ctx_rd_data_i,
  output logic                                   ctx_wr_en_o,
  output logic      [CTX_AW-1:0]                 ctx_wr_addr_o,
  output cpa_pkg::ctx_ent_t                      ctx_wr_data_o,
  // frame stacks
  output logic      [cpa_pkg::COLOR_W+IDX_W-1:0] frm_rd_addr_o,
  input  wire logic [cpa_pkg::FRAME_BITS-1:0]    frm_rd_data_i,
  output logic                                   frm_wr_en_o,
  output logic      [cpa_pkg::COLOR_W+IDX_W-1:0] frm_wr_addr_o,
  output logic      [cpa_pkg::FRAME_BITS-1:0]    frm_wr_data_o
);

  localparam int QW = (CNT_W > cpa_pkg::QUOTA_W) ? CNT_W : cpa_pkg::QUOTA_W;

  cpa_pkg::state_e                  state_q, state_d;
  logic [cpa_pkg::FRAME_BITS-1:0]   frame_q, frame_d;
  logic [CTX_AW-1:0]                ctx_q, ctx_d;
  logic [cpa_pkg::COLOR_W-1:0]      color_q, color_d;
  logic [cpa_pkg::COLOR_W-1:0]      first_q, first_d;
  logic [cpa_pkg::RUN_W-1:0]        count_q, count_d;
  logic [cpa_pkg::COLOR_W-1:0]      cursor_q, cursor_d;
  logic [cpa_pkg::RUN_W-1:0]        tries_q, tries_d;
  logic [cpa_pkg::COLOR_W-1:0]      next_start_q, next_start_d;
  logic [cpa_pkg::QUOTA_W-1:0]      quota_q;
  logic [cpa_pkg::RUN_W-1:0]        run_q;

  cpa_pkg::status_e                 res_status_q, res_status_d;
  logic [cpa_pkg::FRAME_BITS-1:0]   res_frame_q, res_frame_d;
  logic [cpa_pkg::COLOR_W-1:0]      res_color_q, res_color_d;

  logic                             out_valid_q, out_valid_d;
  cpa_pkg::status_e                 out_status_q, out_status_d;
  logic [cpa_pkg::FRAME_BITS-1:0]   out_frame_q, out_frame_d;
  logic [cpa_pkg::COLOR_W-1:0]      out_color_q, out_color_d;

  logic                             ctx_ok;
  logic [cpa_pkg::RUN_W-1:0]        run_sat;
  logic                             full;
  logic [cpa_pkg::COLOR_W-1:0]      step;
  logic [cpa_pkg::RUN_W-1:0]        tries_inc;
  logic [CNT_W-1:0]                 cnt_dec;

  assign req.ready = (state_q == cpa_pkg::S_IDLE);
  assign cfg.ready = 1'b1;

  assign ctx_ok  = (32'(req.context_req) < CONTEXTS);
  assign run_sat = (run_q > cpa_pkg::RUN_W'(cpa_pkg::MAX_RUN)) ?
                   cpa_pkg::RUN_W'(cpa_pkg::MAX_RUN) : run_q;

  // The quota in effect is the smaller of pool_quota and the stack size
  assign full = (QW'(cnt_rd_data_i) >= QW'(quota_q)) ||
                (cnt_rd_data_i == CNT_W'(FRAMES_PER_COLOR));

  // Cursor advance, wrapping at the run length
  assign step      = (cpa_pkg::RUN_W'(cursor_q) + 1'b1 == count_q) ?
                     '0 : cursor_q + 1'b1;
  assign tries_inc = tries_q + 1'b1;
  assign cnt_dec   = cnt_rd_data_i - 1'b1;

  always_comb begin
    state_d       = state_q;
    frame_d       = frame_q;
    ctx_d         = ctx_q;
    color_d       = color_q;
    first_d       = first_q;
    count_d       = count_q;
    cursor_d      = cursor_q;
    tries_d       = tries_q;
    next_start_d  = next_start_q;
    res_status_d  = res_status_q;
    res_frame_d   = res_frame_q;
    res_color_d   = res_color_q;

    out_valid_d   = out_valid_q & ~rsp.ready;
    out_status_d  = out_status_q;
    out_frame_d   = out_frame_q;
    out_color_d   = out_color_q;

    cnt_rd_addr_o = color_q;
    cnt_wr_en_o   = 1'b0;
    cnt_wr_addr_o = color_q;
    cnt_wr_data_o = cnt_rd_data_i;
    ctx_rd_addr_o = ctx_q;
    ctx_wr_en_o   = 1'b0;
    ctx_wr_addr_o = ctx_q;
    ctx_wr_data_o = '{first: first_q, count: count_q, cursor: step};
    frm_rd_addr_o = {color_q, IDX_W'(cnt_dec)};
    frm_wr_en_o   = 1'b0;
    frm_wr_addr_o = {color_q, IDX_W'(cnt_rd_data_i)};
    frm_wr_data_o = frame_q;

    unique case (state_q)
      cpa_pkg::S_IDLE: begin
        if (req.valid) begin
          frame_d     = req.frame;
          ctx_d       = CTX_AW'(req.context_req);
          color_d     = req.frame[cpa_pkg::COLOR_W-1:0];
          res_frame_d = '0;
          res_color_d = '0;
          unique case (cpa_pkg::cmd_e'(req.cmd))
            cpa_pkg::CMD_DEPOSIT: begin
              cnt_rd_addr_o = req.frame[cpa_pkg::COLOR_W-1:0];
              state_d       = cpa_pkg::S_DEP_CHK;
            end
            cpa_pkg::CMD_OPEN: begin
              if (ctx_ok) begin
                ctx_wr_en_o   = 1'b1;
                ctx_wr_addr_o = CTX_AW'(req.context_req);
                ctx_wr_data_o = '{first: next_start_q, count: run_sat, cursor: '0};
                next_start_d  = next_start_q + run_sat[cpa_pkg::COLOR_W-1:0];
                res_status_d  = cpa_pkg::ST_DONE;
                res_color_d   = next_start_q;
              end else begin
                res_status_d  = cpa_pkg::ST_NO_COLORS;
              end
              state_d = cpa_pkg::S_RESP;
            end
            cpa_pkg::CMD_ALLOC: begin
              if (ctx_ok) begin
                ctx_rd_addr_o = CTX_AW'(req.context_req);
                state_d       = cpa_pkg::S_ALC_LD;
              end else begin
                res_status_d  = cpa_pkg::ST_NO_COLORS;
                state_d       = cpa_pkg::S_RESP;
              end
            end
            cpa_pkg::CMD_NONE: begin
              res_status_d = cpa_pkg::ST_DONE;
              state_d      = cpa_pkg::S_RESP;
            end
            default: begin
              state_d = cpa_pkg::S_IDLE;
            end
          endcase
        end
      end

      cpa_pkg::S_DEP_CHK: begin
        res_color_d = color_q;
        if (full) begin
          res_status_d = cpa_pkg::ST_FULL;
        end else begin
          frm_wr_en_o   = 1'b1;
          cnt_wr_en_o   = 1'b1;
          cnt_wr_data_o = cnt_rd_data_i + 1'b1;
          res_status_d  = cpa_pkg::ST_DONE;
        end
        state_d = cpa_pkg::S_RESP;
      end

      cpa_pkg::S_ALC_LD: begin
        first_d  = ctx_rd_data_i.first;
        count_d  = ctx_rd_data_i.count;
        cursor_d = ctx_rd_data_i.cursor;
        tries_d  = '0;
        if (ctx_rd_data_i.count == '0) begin
          res_status_d = cpa_pkg::ST_NO_COLORS;
          state_d      = cpa_pkg::S_RESP;
        end else begin
          color_d       = ctx_rd_data_i.first + ctx_rd_data_i.cursor;
          cnt_rd_addr_o = ctx_rd_data_i.first + ctx_rd_data_i.cursor;
          state_d       = cpa_pkg::S_ALC_CHK;
        end
      end

      // One color try per cycle; the read for the next color goes out here
      cpa_pkg::S_ALC_CHK: begin
        cursor_d = step;
        if (cnt_rd_data_i != '0) begin
          cnt_wr_en_o   = 1'b1;
          cnt_wr_data_o = cnt_dec;
          ctx_wr_en_o   = 1'b1;
          state_d       = cpa_pkg::S_ALC_POP;
        end else if (tries_inc == count_q) begin
          // full turn: cursor is back at its start
          ctx_wr_en_o  = 1'b1;
          res_status_d = cpa_pkg::ST_OOM;
          state_d      = cpa_pkg::S_RESP;
        end else begin
          tries_d       = tries_inc;
          color_d       = first_q + step;
          cnt_rd_addr_o = first_q + step;
        end
      end

      cpa_pkg::S_ALC_POP: begin
        res_status_d = cpa_pkg::ST_DONE;
        res_frame_d  = frm_rd_data_i;
        res_color_d  = color_q;
        state_d      = cpa_pkg::S_RESP;
      end

      cpa_pkg::S_RESP: begin
        // hold until the output register is free
        if (!out_valid_q || rsp.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_frame_d  = res_frame_q;
          out_color_d  = res_color_q;
          state_d      = cpa_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = cpa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= cpa_pkg::S_IDLE;
      out_valid_q  <= 1'b0;
      next_start_q <= '0;
      quota_q      <= cpa_pkg::QUOTA_RESET;
      run_q        <= cpa_pkg::RUN_RESET;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      next_start_q <= next_start_d;
      if (cfg.valid) begin
        unique case (cpa_pkg::cfg_idx_e'(cfg.idx))
          cpa_pkg::CFG_POOL_QUOTA:     quota_q <= cfg.data[cpa_pkg::QUOTA_W-1:0];
          cpa_pkg::CFG_COLORS_PER_CTX: run_q   <= cfg.data[cpa_pkg::RUN_W-1:0];
          default:                     quota_q <= quota_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q      <= frame_d;
    ctx_q        <= ctx_d;
    color_q      <= color_d;
    first_q      <= first_d;
    count_q      <= count_d;
    cursor_q     <= cursor_d;
    tries_q      <= tries_d;
    res_status_q <= res_status_d;
    res_frame_q  <= res_frame_d;
    res_color_q  <= res_color_d;
    out_status_q <= out_status_d;
    out_frame_q  <= out_frame_d;
    out_color_q  <= out_color_d;
  end

  assign rsp.valid     = out_valid_q;
  assign rsp.status    = out_status_q;
  assign rsp.out_frame = out_frame_q;
  assign rsp.out_color = out_color_q;

endmodule

`default_nettype wire

>>> dv/cpa_pool_checker.sv
// ----------------------------------------------------------------------------
// cpa_pool_checker
// Watches the command, result and register channels of the page pool
// allocator. It keeps its own copy of the color stacks and context runs,
// predicts one result per accepted command and compares every accepted
// result, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module cpa_pool_checker (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cpa_req_if        req,
  cpa_rsp_if        rsp,
  cpa_cfg_if        cfg,
  output int        errors_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    cpa_pkg::status_e                status;
    logic [cpa_pkg::FRAME_BITS-1:0]  frame;
    logic [cpa_pkg::COLOR_W-1:0]     color;
  } pool_rsp_t;

  logic [cpa_pkg::FRAME_BITS-1:0] frame_stk [cpa_pkg::COLORS][cpa_pkg::FRAMES_PER_COLOR];
  int unsigned                    fill [cpa_pkg::COLORS];
  int unsigned                    start_ptr;
  int unsigned                    run_first [cpa_pkg::CONTEXTS];
  int unsigned                    run_len [cpa_pkg::CONTEXTS];
  int unsigned                    run_cursor [cpa_pkg::CONTEXTS];
  int unsigned                    quota_reg;
  int unsigned                    run_reg;
  pool_rsp_t                      rsp_due_q [$];
  pool_rsp_t                      want;

  task automatic report(input string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    errors_o++;
  endtask

  // Advance the pool by one command and return the result it must give.
  function automatic pool_rsp_t pool_step(input cpa_pkg::cmd_e c,
                                          input logic [cpa_pkg::FRAME_BITS-1:0] f,
                                          input logic [cpa_pkg::CTX_REQ_W-1:0] x);
    pool_rsp_t   r;
    int unsigned color;
    int unsigned quota;
    int unsigned run;
    int unsigned cur;
    r = '{status: cpa_pkg::ST_DONE, frame: '0, color: '0};
    case (c)
      cpa_pkg::CMD_DEPOSIT: begin
        color = f % cpa_pkg::COLORS;
        quota = (quota_reg > cpa_pkg::FRAMES_PER_COLOR) ? cpa_pkg::FRAMES_PER_COLOR
                                                         : quota_reg;
        if (fill[color] >= quota) begin
          r.status = cpa_pkg::ST_FULL;
        end else begin
          frame_stk[color][fill[color]] = f;
          fill[color]++;
        end
        r.color = color[cpa_pkg::COLOR_W-1:0];
      end
      cpa_pkg::CMD_OPEN: begin
        run = (run_reg > cpa_pkg::MAX_RUN) ? cpa_pkg::MAX_RUN : run_reg;
        run_first[x]  = start_ptr;
        run_len[x]    = run;
        run_cursor[x] = 0;
        r.color       = start_ptr[cpa_pkg::COLOR_W-1:0];
        start_ptr     = (start_ptr + run) % cpa_pkg::COLORS;
      end
      cpa_pkg::CMD_ALLOC: begin
        if (run_len[x] == 0) begin
          r.status = cpa_pkg::ST_NO_COLORS;
        end else begin
          // Scan the run from the cursor; stop at the first color that holds a frame.
          r.status = cpa_pkg::ST_OOM;
          for (int t = 0; t < run_len[x] && r.status == cpa_pkg::ST_OOM; t++) begin
            cur           = run_cursor[x] % run_len[x];
            color         = (run_first[x] + cur) % cpa_pkg::COLORS;
            run_cursor[x] = (cur + 1) % run_len[x];
            if (fill[color] != 0) begin
              fill[color]--;
              r = '{status: cpa_pkg::ST_DONE, frame: frame_stk[color][fill[color]],
                    color: color[cpa_pkg::COLOR_W-1:0]};
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < cpa_pkg::COLORS; i++) fill[i] = 0;
      for (int i = 0; i < cpa_pkg::CONTEXTS; i++) begin
        run_first[i]  = 0;
        run_len[i]    = 0;
        run_cursor[i] = 0;
      end
      start_ptr = 0;
      quota_reg = cpa_pkg::QUOTA_RESET;
      run_reg   = cpa_pkg::RUN_RESET;
      rsp_due_q.delete();
      errors_o  = 0;
    end else begin
      // Results belong to earlier commands, so retire before predicting this edge's item.
      if (rsp.valid && rsp.ready) begin
        if (rsp_due_q.size() == 0) begin
          report("result item with no command waiting");
        end else begin
          want = rsp_due_q.pop_front();
          if (rsp.status !== want.status)
            report($sformatf("status got %0d want %0d", rsp.status, want.status));
          if (rsp.out_frame !== want.frame)
            report($sformatf("out_frame got %0h want %0h", rsp.out_frame, want.frame));
          if (rsp.out_color !== want.color)
            report($sformatf("out_color got %0d want %0d", rsp.out_color, want.color));
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cpa_pkg::cfg_idx_e'(cfg.idx))
          cpa_pkg::CFG_POOL_QUOTA:     quota_reg = cfg.data[cpa_pkg::QUOTA_W-1:0];
          cpa_pkg::CFG_COLORS_PER_CTX: run_reg   = cfg.data[cpa_pkg::RUN_W-1:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready)
        rsp_due_q.push_back(pool_step(cpa_pkg::cmd_e'(req.cmd), req.frame,
                                      req.context_req));
    end
    pending_o = rsp_due_q.size();
  end

endmodule

`default_nettype wire

>>> dv/color_page_pool_allocator_tb.sv
// ----------------------------------------------------------------------------
// color_page_pool_allocator_tb
// Drives deposits, context opens and allocations into the page pool under
// several quota and run-length settings and idling patterns; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module color_page_pool_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 300;
  localparam int HOT_CTX     = 7;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  cpa_req_if req ();
  cpa_rsp_if rsp ();
  cpa_cfg_if cfg ();

  int errors;
  int pending;
  int send_idle_pct = 0;
  int rcv_stall_pct = 0;
  bit hold_go       = 1'b0;
  int n_items       = 0;
  int n_cfg         = 0;

  always #6 clk_i = ~clk_i;

  color_page_pool_allocator uut (
    .clk_i,
    .rst_ni,
    .req_i (req),
    .rsp_o (rsp),
    .cfg_i (cfg)
  );

  cpa_pool_checker chk (
    .clk_i,
    .rst_ni,
    .req       (req),
    .rsp       (rsp),
    .cfg       (cfg),
    .errors_o  (errors),
    .pending_o (pending)
  );

  // Result side: random stalls, or one long hold-off when asked.
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_go) begin
        hold_go   = 1'b0;
        rsp.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        rsp.ready = ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  initial begin
    #(10_000_000);
    $display("color_page_pool_allocator_tb: FAIL");
    $finish;
  end

  task automatic send_req(input cpa_pkg::cmd_e c,
                          input logic [cpa_pkg::FRAME_BITS-1:0] f,
                          input logic [cpa_pkg::CTX_REQ_W-1:0] x);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid = 1'b0;
      @(negedge clk_i);
    end
    req.valid       = 1'b1;
    req.cmd         = c;
    req.frame       = f;
    req.context_req = x;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    @(negedge clk_i);
    n_items++;
  endtask

  // Hold the command side until every result is back.
  task automatic drain();
    req.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input cpa_pkg::cfg_idx_e i,
                           input logic [cpa_pkg::CFG_DATA_W-1:0] d);
    cfg.valid = 1'b1;
    cfg.idx   = i;
    cfg.data  = d;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg.valid = 1'b0;
    n_cfg++;
  endtask

  task automatic rand_item();
    int                              pick;
    cpa_pkg::cmd_e                   c;
    logic [cpa_pkg::FRAME_BITS-1:0]  f;
    logic [cpa_pkg::CTX_REQ_W-1:0]   x;
    pick = $urandom_range(99);
    f    = cpa_pkg::FRAME_BITS'($urandom);
    x    = ($urandom_range(99) < 80) ? cpa_pkg::CTX_REQ_W'($urandom_range(HOT_CTX))
                                     : cpa_pkg::CTX_REQ_W'($urandom);
    if (pick < 45) begin
      c = cpa_pkg::CMD_DEPOSIT;
      // Crowd a few colors so small quotas fill up.
      if ($urandom_range(99) < 30) begin
        f[cpa_pkg::COLOR_W-1:0] = cpa_pkg::COLOR_W'($urandom_range(3));
      end
    end else if (pick < 83) begin
      c = cpa_pkg::CMD_ALLOC;
    end else if (pick < 95) begin
      c = cpa_pkg::CMD_OPEN;
    end else begin
      c = cpa_pkg::CMD_NONE;
    end
    send_req(c, f, x);
  endtask

  task automatic run_phase(input int n, input logic [cpa_pkg::CFG_DATA_W-1:0] quota,
                           input logic [cpa_pkg::CFG_DATA_W-1:0] run, input int s_pct,
                           input int r_pct);
    drain();
    write_reg(cpa_pkg::CFG_POOL_QUOTA, quota);
    write_reg(cpa_pkg::CFG_COLORS_PER_CTX, run);
    send_idle_pct = s_pct;
    rcv_stall_pct = r_pct;
    for (int i = 0; i <= HOT_CTX; i += 2) begin
      send_req(cpa_pkg::CMD_OPEN, cpa_pkg::FRAME_BITS'($urandom), cpa_pkg::CTX_REQ_W'(i));
    end
    repeat (n) rand_item();
  endtask

  initial begin
    int pct [3];
    pct = '{0, 74, 33};
    req.valid       = 1'b0;
    req.cmd         = cpa_pkg::CMD_DEPOSIT;
    req.frame       = '0;
    req.context_req = '0;
    cfg.valid       = 1'b0;
    cfg.idx         = cpa_pkg::CFG_POOL_QUOTA;
    cfg.data        = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part, starting at reset settings.
    send_req(cpa_pkg::CMD_ALLOC, '0, 6'd5);
    send_req(cpa_pkg::CMD_NONE, 20'hFFFFF, 6'd63);
    send_req(cpa_pkg::CMD_DEPOSIT, 20'h00000, 6'd0);
    send_req(cpa_pkg::CMD_DEPOSIT, 20'hFFFFF, 6'd0);
    send_req(cpa_pkg::CMD_DEPOSIT, 20'h00040, 6'd0);
    send_req(cpa_pkg::CMD_OPEN, '0, 6'd0);
    send_req(cpa_pkg::CMD_ALLOC, '0, 6'd0);
    send_req(cpa_pkg::CMD_ALLOC, '0, 6'd0);
    send_req(cpa_pkg::CMD_ALLOC, '0, 6'd0);
    send_req(cpa_pkg::CMD_OPEN, '0, 6'd63);
    send_req(cpa_pkg::CMD_OPEN, '0, 6'd62);
    send_req(cpa_pkg::CMD_OPEN, '0, 6'd61);
    send_req(cpa_pkg::CMD_ALLOC, '0, 6'd61);
    drain();
    write_reg(cpa_pkg::CFG_POOL_QUOTA, 11'd0);
    send_req(cpa_pkg::CMD_DEPOSIT, 20'h12345, 6'd0);
    drain();
    write_reg(cpa_pkg::CFG_POOL_QUOTA, 11'd1);
    send_req(cpa_pkg::CMD_DEPOSIT, 20'h00007, 6'd0);
    send_req(cpa_pkg::CMD_DEPOSIT, 20'h00047, 6'd0);
    drain();
    write_reg(cpa_pkg::CFG_POOL_QUOTA, 11'h7FF);
    write_reg(cpa_pkg::CFG_COLORS_PER_CTX, 11'd0);
    send_req(cpa_pkg::CMD_OPEN, '0, 6'd1);
    send_req(cpa_pkg::CMD_ALLOC, '0, 6'd1);
    drain();
    write_reg(cpa_pkg::CFG_COLORS_PER_CTX, 11'd127);
    send_req(cpa_pkg::CMD_OPEN, '0, 6'd2);
    send_req(cpa_pkg::CMD_ALLOC, '0, 6'd2);
    send_req(cpa_pkg::CMD_ALLOC, '0, 6'd2);
    drain();
    write_reg(cpa_pkg::CFG_COLORS_PER_CTX, 11'h7C0);
    send_req(cpa_pkg::CMD_OPEN, '0, 6'd3);

    // Random part.
    run_phase(330, 11'd1024, 11'd16, 0, 0);
    run_phase(330, 11'd3, 11'd4, 74, 0);
    run_phase(200, 11'h7FF, 11'd64, 0, 74);
    hold_go = 1'b1;
    repeat (140) rand_item();
    run_phase(330, 11'd1, 11'd1, 33, 33);
    repeat (4) begin
      run_phase(80, cpa_pkg::CFG_DATA_W'($urandom_range(2047)),
                cpa_pkg::CFG_DATA_W'($urandom),
                pct[$urandom_range(2)], pct[$urandom_range(2)]);
    end

    drain();
    repeat (80) @(negedge clk_i);
    $display("Ran %0d command items over %0d register writes: quotas 0 to 2047, runs 0 to 127,",
             n_items, n_cfg);
    $display("full stacks, empty runs, out-of-memory scans, a %0d-cycle result hold-off.",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("color_page_pool_allocator_tb: PASS");
    end else begin
      $display("color_page_pool_allocator_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
hdl/cpa_pkg.sv
hdl/cpa_req_if.sv
hdl/cpa_rsp_if.sv
hdl/cpa_cfg_if.sv
hdl/cpa_count_mem.sv
hdl/cpa_ctx_mem.sv
hdl/cpa_frame_mem.sv
hdl/cpa_seq.sv
hdl/color_page_pool_allocator.sv
dv/cpa_pool_checker.sv
dv/color_page_pool_allocator_tb.sv
